@@ design/esc_pkg.sv @@
`timescale 1ns / 1ps
package esc_pkg;

	typedef logic [63:0] dword_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_TEMP    = 3'd0,
		CFG_PRESS_A = 3'd1,
		CFG_PRESS_B = 3'd2,
		CFG_PRESS_C = 3'd3,
		CFG_HUM_A   = 3'd4,
		CFG_HUM_B   = 3'd5
	} cfg_idx_t;

	// restoring divider: one quotient bit per stage, plus abs and sign-fix stages
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned DIV_LAT   = DIV_STEPS + 2;

	// stage at which the quotient leaves the divider, and the output stage
	localparam int unsigned STG_DIV_IN = 12;
	localparam int unsigned STG_QUO    = STG_DIV_IN + DIV_LAT;
	localparam int unsigned STG_OUT    = STG_QUO + 6;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
		return $unsigned($signed(x) >>> sh);
	endfunction

	function automatic dword_t asr64(input dword_t x, input int unsigned sh);
		return $unsigned($signed(x) >>> sh);
	endfunction

endpackage

@@ design/esc_mul64.sv @@
`timescale 1ns / 1ps
module esc_mul64 (
	input  logic            clk,
	input  esc_pkg::dword_t a,
	input  esc_pkg::dword_t b,
	output esc_pkg::dword_t p
);

	// product modulo 2^64 from three 32x32 partial products
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;

	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= 32'(a[31:0] * b[63:32]);
		hl_s1 <= 32'(a[63:32] * b[31:0]);
	end

	always_ff @(posedge clk) begin
		p <= ll_s1 + {32'(lh_s1 + hl_s1), 32'b0};
	end

endmodule

@@ design/esc_sdiv.sv @@
`timescale 1ns / 1ps
module esc_sdiv (
	input  logic            clk,
	input  esc_pkg::dword_t num,
	input  esc_pkg::dword_t den,
	output esc_pkg::dword_t quo
);

	localparam int unsigned N = esc_pkg::DIV_STEPS;

	logic [63:0] rem_s [0:N-1];
	logic [63:0] dvd_s [0:N-1];
	logic [63:0] dsr_s [0:N-1];
	logic [63:0] qt_s  [0:N];
	logic        neg_s [0:N];

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		neg_s[0] <= num[63] ^ den[63];
		dvd_s[0] <= num[63] ? 64'(64'd0 - num) : num;
		dsr_s[0] <= den[63] ? 64'(64'd0 - den) : den;
		rem_s[0] <= '0;
		qt_s[0]  <= '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [64:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], dvd_s[k][63]};
			ge    = trial >= {1'b0, dsr_s[k]};
		end

		always_ff @(posedge clk) begin
			qt_s[k+1]  <= {qt_s[k][62:0], ge};
			neg_s[k+1] <= neg_s[k];
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? 64'(trial - {1'b0, dsr_s[k]}) : trial[63:0];
				dvd_s[k+1] <= {dvd_s[k][62:0], 1'b0};
				dsr_s[k+1] <= dsr_s[k];
			end
		end
	end

	// truncation toward zero: negate the magnitude quotient when signs differ
	always_ff @(posedge clk) begin
		quo <= neg_s[N] ? 64'(64'd0 - qt_s[N]) : qt_s[N];
	end

endmodule

@@ design/env_sensor_compensation.sv @@
`timescale 1ns / 1ps
// Integer compensation of one raw pressure / temperature / humidity sample.
// Input: raise start with raw_pressure, raw_temperature and raw_humidity;
// the word is taken at a clock edge where start is high and busy is low.
// busy stays low, so a new word may be offered in every cycle.
// Output: done is high for exactly one cycle with temp_centi, pressure_q24_8,
// pressure_valid and humidity_q22_10; the receiver cannot hold it off.
// Throughput is one word per cycle. Most of the pipeline depth is the 64-stage
// signed divider of the pressure path, one quotient bit per stage, plus the
// 64-bit products built from 32x32 partial products over two stages each.
// Calibration registers are written over cfg_valid / cfg_ready with an index
// and up to 48 data bits; cfg_ready is always high. Write them only while no
// word is in flight. An index beyond the last register is ignored.
// Reset clears all calibration registers and empties the pipeline; no result
// is produced for words in flight at reset. No clearing pass is needed.
module env_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [19:0] raw_pressure,
	input  logic [19:0] raw_temperature,
	input  logic [15:0] raw_humidity,
	output logic        done,
	output logic [31:0] temp_centi,
	output logic [31:0] pressure_q24_8,
	output logic        pressure_valid,
	output logic [16:0] humidity_q22_10,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int unsigned SO = esc_pkg::STG_OUT;
	localparam int unsigned SQ = esc_pkg::STG_QUO;

	// calibration registers
	logic [47:0] temp_cal_q;
	logic [47:0] press_cal_a_q;
	logic [47:0] press_cal_b_q;
	logic [47:0] press_cal_c_q;
	logic [31:0] hum_cal_a_q;
	logic [31:0] hum_cal_b_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
			hum_cal_a_q   <= '0;
			hum_cal_b_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (esc_pkg::cfg_idx_t'(cfg_index))
				esc_pkg::CFG_TEMP:    temp_cal_q    <= cfg_data;
				esc_pkg::CFG_PRESS_A: press_cal_a_q <= cfg_data;
				esc_pkg::CFG_PRESS_B: press_cal_b_q <= cfg_data;
				esc_pkg::CFG_PRESS_C: press_cal_c_q <= cfg_data;
				esc_pkg::CFG_HUM_A:   hum_cal_a_q   <= cfg_data[31:0];
				esc_pkg::CFG_HUM_B:   hum_cal_b_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// coefficient fields; the user must keep them stable while words are in flight, the block does not enforce it
	logic [31:0] t1, t2, t3;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	always_comb begin
		t1 = {16'b0, temp_cal_q[15:0]};
		t2 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
		t3 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
		h1 = {24'b0, hum_cal_a_q[7:0]};
		h2 = {{16{hum_cal_a_q[23]}}, hum_cal_a_q[23:8]};
		h3 = {24'b0, hum_cal_a_q[31:24]};
		h4 = {{20{hum_cal_b_q[11]}}, hum_cal_b_q[11:0]};
		h5 = {{20{hum_cal_b_q[23]}}, hum_cal_b_q[23:12]};
		h6 = {{24{hum_cal_b_q[31]}}, hum_cal_b_q[31:24]};
		p1 = {48'b0, press_cal_a_q[15:0]};
		p2 = {{48{press_cal_a_q[31]}}, press_cal_a_q[31:16]};
		p3 = {{48{press_cal_a_q[47]}}, press_cal_a_q[47:32]};
		p4 = {{48{press_cal_b_q[15]}}, press_cal_b_q[15:0]};
		p5 = {{48{press_cal_b_q[31]}}, press_cal_b_q[31:16]};
		p6 = {{48{press_cal_b_q[47]}}, press_cal_b_q[47:32]};
		p7 = {{48{press_cal_c_q[15]}}, press_cal_c_q[15:0]};
		p8 = {{48{press_cal_c_q[31]}}, press_cal_c_q[31:16]};
		p9 = {{48{press_cal_c_q[47]}}, press_cal_c_q[47:32]};
	end

	// valid bits
	logic vld_s [1:SO];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= SO; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int i = 2; i <= SO; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- temperature ----------------
	logic [31:0] d_in, e_in;
	logic [31:0] m1_s1, m2_s1;
	logic [19:0] ap_s [1:9];
	logic [15:0] ah_s [1:5];
	logic [31:0] v1_s2, m3_s2;
	logic [31:0] tf_s3;
	logic [31:0] x_s4;
	logic [63:0] w1_s4;
	logic [31:0] temp_s [4:SO];

	always_comb begin
		d_in = 32'({12'b0, raw_temperature} >> 3) - 32'(t1 << 1);
		e_in = 32'({12'b0, raw_temperature} >> 4) - t1;
	end

	always_ff @(posedge clk) begin
		m1_s1 <= 32'(d_in * t2);
		m2_s1 <= 32'(e_in * e_in);
		ap_s[1] <= raw_pressure;
		ah_s[1] <= raw_humidity;
		for (int i = 2; i <= 9; i++) ap_s[i] <= ap_s[i-1];
		for (int i = 2; i <= 5; i++) ah_s[i] <= ah_s[i-1];
		v1_s2 <= esc_pkg::asr32(m1_s1, 11);
		m3_s2 <= 32'(esc_pkg::asr32(m2_s1, 12) * t3);
		tf_s3 <= v1_s2 + esc_pkg::asr32(m3_s2, 14);
		temp_s[4] <= esc_pkg::asr32(32'(32'(tf_s3 * 32'd5) + 32'd128), 8);
		for (int i = 5; i <= SO; i++) temp_s[i] <= temp_s[i-1];
		x_s4  <= tf_s3 - 32'd76800;
		w1_s4 <= {{32{tf_s3[31]}}, tf_s3} - 64'd128000;
	end

	// ---------------- humidity ----------------
	logic [31:0] h5x_s5, mx6_s5, mx3_s5;
	logic [31:0] a_s6, hb_s6, a_s7, hc_s7, a_s8, b_s8;
	logic [31:0] hx_s9, hx_s10, hx_s11, ss_s10, sh_s11;
	logic [31:0] s_c, hv_c, hcl_c;
	logic [16:0] hum_s [12:SO];

	always_comb begin
		s_c  = esc_pkg::asr32(hx_s9, 15);
		hv_c = hx_s11 - esc_pkg::asr32(sh_s11, 4);
		if (hv_c[31]) begin
			hcl_c = '0;
		end else if (hv_c > 32'd419430400) begin
			hcl_c = 32'd419430400;
		end else begin
			hcl_c = hv_c;
		end
	end

	always_ff @(posedge clk) begin
		h5x_s5 <= 32'(h5 * x_s4);
		mx6_s5 <= 32'(x_s4 * h6);
		mx3_s5 <= 32'(x_s4 * h3);
		a_s6 <= esc_pkg::asr32(32'(32'({16'b0, ah_s[5]} << 14) - 32'(h4 << 20) - h5x_s5
			+ 32'd16384), 15);
		hb_s6 <= 32'(esc_pkg::asr32(mx6_s5, 10)
			* 32'(esc_pkg::asr32(mx3_s5, 11) + 32'd32768));
		a_s7  <= a_s6;
		hc_s7 <= 32'(32'(esc_pkg::asr32(hb_s6, 10) + 32'd2097152) * h2);
		a_s8  <= a_s7;
		b_s8  <= esc_pkg::asr32(32'(hc_s7 + 32'd8192), 14);
		hx_s9 <= 32'(a_s8 * b_s8);
		hx_s10 <= hx_s9;
		ss_s10 <= 32'(s_c * s_c);
		hx_s11 <= hx_s10;
		sh_s11 <= 32'(esc_pkg::asr32(ss_s10, 7) * h1);
		hum_s[12] <= hcl_c[28:12];
		for (int i = 13; i <= SO; i++) hum_s[i] <= hum_s[i-1];
	end

	// ---------------- pressure ----------------
	esc_pkg::dword_t sq_s6, w1p5_s6, w1p2_s6;
	esc_pkg::dword_t w2a_s8, w1p3_s8;
	esc_pkg::dword_t w1p5_s7, w1p5_s8, w1p2_s7, w1p2_s8;
	esc_pkg::dword_t w2_s9, w1b_s9, numpre_s10, prod_s11, num_s12, w1c_s12;
	esc_pkg::dword_t pp_c;
	logic            pv_s [13:SO];

	esc_mul64 u_sq (.clk(clk), .a(w1_s4), .b(w1_s4), .p(sq_s6));
	esc_mul64 u_p5 (.clk(clk), .a(w1_s4), .b(p5), .p(w1p5_s6));
	esc_mul64 u_p2 (.clk(clk), .a(w1_s4), .b(p2), .p(w1p2_s6));
	esc_mul64 u_p6 (.clk(clk), .a(sq_s6), .b(p6), .p(w2a_s8));
	esc_mul64 u_p3 (.clk(clk), .a(sq_s6), .b(p3), .p(w1p3_s8));
	esc_mul64 u_p1 (.clk(clk), .a(w1b_s9), .b(p1), .p(prod_s11));
	esc_mul64 u_k  (.clk(clk), .a(numpre_s10), .b(64'd3125), .p(num_s12));

	assign pp_c = 64'd1048576 - {44'b0, ap_s[9]};

	always_ff @(posedge clk) begin
		w1p5_s7 <= w1p5_s6;
		w1p5_s8 <= w1p5_s7;
		w1p2_s7 <= w1p2_s6;
		w1p2_s8 <= w1p2_s7;
		w2_s9  <= w2a_s8 + (w1p5_s8 << 17) + (p4 << 35);
		w1b_s9 <= esc_pkg::asr64(w1p3_s8, 8) + (w1p2_s8 << 12) + (64'd1 << 47);
		numpre_s10 <= (pp_c << 31) - w2_s9;
		w1c_s12 <= esc_pkg::asr64(prod_s11, 33);
		pv_s[13] <= w1c_s12 != '0;
		for (int i = 14; i <= SO; i++) pv_s[i] <= pv_s[i-1];
	end

	esc_pkg::dword_t quo_w;

	esc_sdiv u_div (.clk(clk), .num(num_s12), .den(w1c_s12), .quo(quo_w));

	// post-division correction
	esc_pkg::dword_t p_s [SQ+1:SQ+4];
	esc_pkg::dword_t q_s [SQ+1:SQ+2];
	esc_pkg::dword_t p9q_w, p8p_w, p9qq_w;
	esc_pkg::dword_t p8p_s [SQ+3:SQ+4];
	esc_pkg::dword_t sum_s;
	esc_pkg::dword_t pfin_c;
	logic [31:0]     press_s;

	esc_mul64 u_p9 (.clk(clk), .a(p9), .b(esc_pkg::asr64(quo_w, 13)), .p(p9q_w));
	esc_mul64 u_p8 (.clk(clk), .a(p8), .b(quo_w), .p(p8p_w));
	esc_mul64 u_qq (.clk(clk), .a(p9q_w), .b(q_s[SQ+2]), .p(p9qq_w));

	assign pfin_c = esc_pkg::asr64(sum_s, 8) + (p7 << 4);

	always_ff @(posedge clk) begin
		p_s[SQ+1] <= quo_w;
		for (int i = SQ + 2; i <= SQ + 4; i++) p_s[i] <= p_s[i-1];
		q_s[SQ+1] <= esc_pkg::asr64(quo_w, 13);
		q_s[SQ+2] <= q_s[SQ+1];
		p8p_s[SQ+3] <= p8p_w;
		p8p_s[SQ+4] <= p8p_s[SQ+3];
		sum_s <= p_s[SQ+4] + esc_pkg::asr64(p9qq_w, 25) + esc_pkg::asr64(p8p_s[SQ+4], 19);
		press_s <= pv_s[SO-1] ? pfin_c[31:0] : 32'd0;
	end

	assign done            = vld_s[SO];
	assign temp_centi      = temp_s[SO];
	assign pressure_q24_8  = press_s;
	assign pressure_valid  = pv_s[SO];
	assign humidity_q22_10 = hum_s[SO];

`ifndef SYNTHESIS
	// every accepted word raises the result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##84 done)
		else $error("result strobe missing at pipeline latency");

	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pressure_valid) |-> (pressure_q24_8 == 32'd0))
		else $error("invalid pressure word not zero");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (humidity_q22_10 <= 17'd102400))
		else $error("humidity above full scale");
`endif

endmodule

@@ dv/tb_env_sensor_compensation.sv @@
`timescale 1ns / 1ps
module tb_env_sensor_compensation;

	localparam int unsigned LATENCY  = 84;
	localparam int unsigned WATCHDOG = 3000;
	localparam int unsigned PHASE_WORDS = 148;
	localparam int unsigned NUM_PHASES  = 7;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} reading_t;

	typedef struct packed {
		logic [19:0] p;
		logic [19:0] t;
		logic [15:0] h;
		logic        typical_cal;
		logic        typed;
		reading_t    want;
	} stim_row_t;

	localparam reading_t ZERO_READING = '0;

	// first rows run on the reset calibration, where every output is zero
	localparam stim_row_t DIRECTED [14] = '{
		'{20'h00000, 20'h00000, 16'h0000, 1'b0, 1'b1, ZERO_READING},
		'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, 1'b1, ZERO_READING},
		'{20'hFFFFF, 20'h00000, 16'h0000, 1'b0, 1'b1, ZERO_READING},
		'{20'h00000, 20'hFFFFF, 16'hFFFF, 1'b0, 1'b1, ZERO_READING},
		'{20'h80000, 20'h80000, 16'h8000, 1'b0, 1'b1, ZERO_READING},
		'{20'hAAAAA, 20'h55555, 16'h5555, 1'b0, 1'b1, ZERO_READING},
		'{20'h6559C, 20'h7EED0, 16'h7530, 1'b1, 1'b0, ZERO_READING},
		'{20'h00000, 20'h00000, 16'h0000, 1'b1, 1'b0, ZERO_READING},
		'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b0, ZERO_READING},
		'{20'h00000, 20'hFFFFF, 16'h0000, 1'b1, 1'b0, ZERO_READING},
		'{20'hFFFFF, 20'h00000, 16'hFFFF, 1'b1, 1'b0, ZERO_READING},
		'{20'h80000, 20'h7FFFF, 16'h8000, 1'b1, 1'b0, ZERO_READING},
		'{20'h55555, 20'hAAAAA, 16'hAAAA, 1'b1, 1'b0, ZERO_READING},
		'{20'h5A000, 20'h82000, 16'hA000, 1'b1, 1'b0, ZERO_READING}
	};

	localparam logic [47:0] TYP_TEMP    = 48'hFC18_6743_6B70;
	localparam logic [47:0] TYP_PRESS_A = 48'h0BD0_D643_8E7D;
	localparam logic [47:0] TYP_PRESS_B = 48'hFFF9_008C_0B27;
	localparam logic [47:0] TYP_PRESS_C = 48'h1770_C6F8_3C8C;
	localparam logic [47:0] TYP_HUM_A   = 48'h0000_0001_6A4B;
	localparam logic [47:0] TYP_HUM_B   = 48'h0000_1E03_2139;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [19:0] raw_pressure;
	logic [19:0] raw_temperature;
	logic [15:0] raw_humidity;
	logic        done;
	logic [31:0] temp_centi;
	logic [31:0] pressure_q24_8;
	logic        pressure_valid;
	logic [16:0] humidity_q22_10;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	logic        typed_word;
	reading_t    typed_reading;

	logic [47:0] cal [6];
	reading_t    pending_readings [$];
	int unsigned mismatches;
	int unsigned quiet_cycles;

	env_sensor_compensation u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.done            (done),
		.temp_centi      (temp_centi),
		.pressure_q24_8  (pressure_q24_8),
		.pressure_valid  (pressure_valid),
		.humidity_q22_10 (humidity_q22_10),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sext16(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

	// signed quotient truncated toward zero, most negative / -1 wraps
	function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] q;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q  = ua / ub;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic reading_t compensate(input logic [19:0] ap, input logic [19:0] at,
	                                        input logic [15:0] ah);
		reading_t    r;
		logic [31:0] t1, t2, t3, d, e, v1, v2, tf, x, a, b, s, ah32;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q;
		t1 = {16'h0, cal[esc_pkg::CFG_TEMP][15:0]};
		t2 = {{16{cal[esc_pkg::CFG_TEMP][31]}}, cal[esc_pkg::CFG_TEMP][31:16]};
		t3 = {{16{cal[esc_pkg::CFG_TEMP][47]}}, cal[esc_pkg::CFG_TEMP][47:32]};
		d  = {12'h0, at} >> 3;
		d  = d - (t1 << 1);
		v1 = sra32(d * t2, 11);
		e  = ({12'h0, at} >> 4) - t1;
		v2 = sra32(sra32(e * e, 12) * t3, 14);
		tf = v1 + v2;
		r.temp = sra32(tf * 32'd5 + 32'd128, 8);

		p1 = {48'h0, cal[esc_pkg::CFG_PRESS_A][15:0]};
		p2 = sext16(cal[esc_pkg::CFG_PRESS_A][31:16]);
		p3 = sext16(cal[esc_pkg::CFG_PRESS_A][47:32]);
		p4 = sext16(cal[esc_pkg::CFG_PRESS_B][15:0]);
		p5 = sext16(cal[esc_pkg::CFG_PRESS_B][31:16]);
		p6 = sext16(cal[esc_pkg::CFG_PRESS_B][47:32]);
		p7 = sext16(cal[esc_pkg::CFG_PRESS_C][15:0]);
		p8 = sext16(cal[esc_pkg::CFG_PRESS_C][31:16]);
		p9 = sext16(cal[esc_pkg::CFG_PRESS_C][47:32]);
		w1 = {{32{tf[31]}}, tf} - 64'd128000;
		w2 = w1 * w1 * p6;
		w2 = w2 + ((w1 * p5) << 17);
		w2 = w2 + (p4 << 35);
		w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
		w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
		r.press  = '0;
		r.pvalid = 1'b0;
		if (w1 != 64'd0) begin
			p  = 64'd1048576 - {44'h0, ap};
			p  = div_trunc(((p << 31) - w2) * 64'd3125, w1);
			q  = sra64(p, 13);
			w1 = sra64(p9 * q * q, 25);
			w2 = sra64(p8 * p, 19);
			p  = sra64(p + w1 + w2, 8) + (p7 << 4);
			r.press  = p[31:0];
			r.pvalid = 1'b1;
		end

		h1 = {24'h0, cal[esc_pkg::CFG_HUM_A][7:0]};
		h2 = {{16{cal[esc_pkg::CFG_HUM_A][23]}}, cal[esc_pkg::CFG_HUM_A][23:8]};
		h3 = {24'h0, cal[esc_pkg::CFG_HUM_A][31:24]};
		h4 = {{20{cal[esc_pkg::CFG_HUM_B][11]}}, cal[esc_pkg::CFG_HUM_B][11:0]};
		h5 = {{20{cal[esc_pkg::CFG_HUM_B][23]}}, cal[esc_pkg::CFG_HUM_B][23:12]};
		h6 = {{24{cal[esc_pkg::CFG_HUM_B][31]}}, cal[esc_pkg::CFG_HUM_B][31:24]};
		ah32 = {16'h0, ah};
		x = tf - 32'd76800;
		a = sra32((ah32 << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		b = sra32(sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768), 10);
		b = sra32((b + 32'd2097152) * h2 + 32'd8192, 14);
		x = a * b;
		s = sra32(x, 15);
		x = x - sra32(sra32(s * s, 7) * h1, 4);
		if (x[31])
			x = '0;
		else if (x > 32'd419430400)
			x = 32'd419430400;
		r.hum = x[28:12];
		return r;
	endfunction

	// predictor bookkeeping, result check and watchdog
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_readings.size() == 0) begin
					$error("unexpected result word");
					mismatches++;
				end else begin
					want = pending_readings.pop_front();
					if (temp_centi !== want.temp) begin
						$error("temp_centi exp %0h got %0h", want.temp, temp_centi);
						mismatches++;
					end
					if (pressure_q24_8 !== want.press) begin
						$error("pressure_q24_8 exp %0h got %0h", want.press, pressure_q24_8);
						mismatches++;
					end
					if (pressure_valid !== want.pvalid) begin
						$error("pressure_valid exp %0b got %0b", want.pvalid, pressure_valid);
						mismatches++;
					end
					if (humidity_q22_10 !== want.hum) begin
						$error("humidity_q22_10 exp %0h got %0h", want.hum, humidity_q22_10);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					esc_pkg::CFG_TEMP, esc_pkg::CFG_PRESS_A, esc_pkg::CFG_PRESS_B,
					esc_pkg::CFG_PRESS_C: begin
						cal[cfg_index] = cfg_data;
					end
					esc_pkg::CFG_HUM_A, esc_pkg::CFG_HUM_B: begin
						cal[cfg_index] = {16'h0, cfg_data[31:0]};
					end
					default: ;
				endcase
			end
			if (start && !busy)
				pending_readings.push_back(typed_word ? typed_reading
					: compensate(raw_pressure, raw_temperature, raw_humidity));
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// leaves start high after acceptance; the caller lowers it for a gap
	task automatic send_word(input logic [19:0] p, input logic [19:0] t, input logic [15:0] h,
	                         input logic typed, input reading_t want);
		start           <= 1'b1;
		raw_pressure    <= p;
		raw_temperature <= t;
		raw_humidity    <= h;
		typed_word      <= typed;
		typed_reading   <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [47:0] rnd48();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic load_cal(input logic [47:0] tc, input logic [47:0] pa, input logic [47:0] pb,
	                        input logic [47:0] pc, input logic [47:0] ha, input logic [47:0] hb,
	                        input logic spare);
		write_reg(esc_pkg::CFG_TEMP, tc);
		write_reg(esc_pkg::CFG_PRESS_A, pa);
		write_reg(esc_pkg::CFG_PRESS_B, pb);
		write_reg(esc_pkg::CFG_PRESS_C, pc);
		write_reg(esc_pkg::CFG_HUM_A, ha);
		write_reg(esc_pkg::CFG_HUM_B, hb);
		if (spare) begin
			write_reg(CFG_SPARE_LO, rnd48());
			write_reg(CFG_SPARE_HI, rnd48());
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [19:0] rnd20();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 20'(20'h60000 + $urandom_range(0, 20'h1FFFF));
			default: return 20'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned burst;
		int unsigned gap;
		arst_n          = 1'b0;
		start           = 1'b0;
		raw_pressure    = '0;
		raw_temperature = '0;
		raw_humidity    = '0;
		typed_word      = 1'b0;
		typed_reading   = '0;
		cfg_valid       = 1'b0;
		cfg_index       = esc_pkg::CFG_TEMP;
		cfg_data        = '0;
		mismatches      = 0;
		quiet_cycles    = 0;
		foreach (cal[i]) cal[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].typical_cal && (i == 0 || !DIRECTED[i - 1].typical_cal)) begin
				drain();
				load_cal(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_C,
				         TYP_HUM_A, TYP_HUM_B, 1'b1);
			end
			send_word(DIRECTED[i].p, DIRECTED[i].t, DIRECTED[i].h,
			          DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: load_cal(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_C,
				            TYP_HUM_A, TYP_HUM_B, 1'b0);
				1: load_cal('1, '1, '1, '1, '1, '1, 1'b0);
				2: load_cal(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), 1'b1);
				3: load_cal({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
				            48'h8000_8080_0080, 48'h0000_8080_0800, 1'b0);
				// divisor forced to zero by a null P1
				4: load_cal(rnd48(), rnd48() & ~48'hFFFF, rnd48(), rnd48(),
				            rnd48(), rnd48(), 1'b0);
				5: load_cal(TYP_TEMP ^ 48'($urandom & 16'h00FF),
				            TYP_PRESS_A ^ 48'($urandom & 8'hFF),
				            TYP_PRESS_B ^ 48'($urandom & 8'h3F),
				            TYP_PRESS_C ^ 48'($urandom & 8'hFF),
				            TYP_HUM_A ^ 48'($urandom & 16'h0F0F),
				            TYP_HUM_B ^ 48'($urandom & 8'hFF),
				            1'b0);
				default: load_cal('0, '0, '0, '0, '0, '0, 1'b0);
			endcase
			for (int n = 0; n < PHASE_WORDS; ) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst && n < PHASE_WORDS; k++, n++)
					send_word(rnd20(), rnd20(), 16'($urandom), 1'b0, ZERO_READING);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		fork
			begin
				do @(posedge clk); while (pending_readings.size() != 0);
				repeat (LATENCY + 4) @(posedge clk);
			end
			begin
				repeat (20 * LATENCY) @(posedge clk);
				mismatches++;
			end
		join_any
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
